// ===== hdl/emmb_pkg.sv =====
// Package with shared types, constants and the quarter-wave sine function for the matrix builder.
`timescale 1ns / 1ps
`default_nettype none
package emmb_pkg;

	localparam int TrigBits = 12;
	localparam int FracBits = 16;
	localparam int QtrN = 1 << TrigBits;
	localparam logic signed [31:0] OneQ = 32'sd1 <<< FracBits;

	// Reciprocals of the series divisors, rounded up, for exact division of values below 2^32.
	localparam int RecipShift = 40;
	localparam longint unsigned Recip110 = ((64'd1 << 40) + 64'd109) / 64'd110;
	localparam longint unsigned Recip72  = ((64'd1 << 40) + 64'd71) / 64'd72;
	localparam longint unsigned Recip42  = ((64'd1 << 40) + 64'd41) / 64'd42;
	localparam longint unsigned Recip20  = ((64'd1 << 40) + 64'd19) / 64'd20;
	localparam longint unsigned Recip6   = ((64'd1 << 40) + 64'd5) / 64'd6;

	typedef enum logic [2:0] {
		CMD_SET_POS = 3'd0,
		CMD_SET_ORI = 3'd1,
		CMD_SET_SCL = 3'd2,
		CMD_MOVE    = 3'd3,
		CMD_ROTATE  = 3'd4,
		CMD_GROW    = 3'd5
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_TRIG,
		ST_MUL_A,
		ST_MUL_R,
		ST_SCALE,
		ST_EMIT
	} state_t;

	// Quarter-wave sine entry, evaluated for each entry of the constant table.
	// The series term stays below 2^32, so the rounded-up reciprocal gives the exact quotient.
	function automatic logic [FracBits:0] quarter_sine(input int unsigned i);
		longint unsigned x, x2, t, s, q, n;
		longint unsigned recip [5];
		recip[0] = Recip110; recip[1] = Recip72; recip[2] = Recip42;
		recip[3] = Recip20; recip[4] = Recip6;
		if (i >= QtrN) return (FracBits+1)'(OneQ);
		x = (longint'(i) * 64'd1686629713) >> TrigBits;
		x2 = (x * x) >> 30;
		t = 64'd1 << 30;
		for (int k = 0; k < 5; k++) begin
			n = (x2 * t) >> 30;
			t = (64'd1 << 30) - 64'((80'(n) * 80'(recip[k])) >> RecipShift);
		end
		s = (x * t) >> 30;
		if (s > (64'd1 << 30)) s = 64'd1 << 30;
		q = (s + (64'd1 << (29 - FracBits))) >> (30 - FracBits);
		if (q > (64'd1 << FracBits)) q = 64'd1 << FracBits;
		return q[FracBits:0];
	endfunction

endpackage
`default_nettype wire

// ===== hdl/emmb_if.sv =====
// Valid/ready channel interface for items in and out of the matrix builder.
`timescale 1ns / 1ps
`default_nettype none
interface emmb_in_if;
	logic        valid;
	logic        ready;
	logic [2:0]  cmd;
	logic signed [31:0] value_x;
	logic signed [31:0] value_y;
	logic signed [31:0] value_z;
	modport source (output valid, cmd, value_x, value_y, value_z, input ready);
	modport sink (input valid, cmd, value_x, value_y, value_z, output ready);
endinterface

interface emmb_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  column;
	logic signed [31:0] row0;
	logic signed [31:0] row1;
	logic signed [31:0] row2;
	logic signed [31:0] row3;
	logic        last;
	modport source (output valid, column, row0, row1, row2, row3, last, input ready);
	modport sink (input valid, column, row0, row1, row2, row3, last, output ready);
endinterface
`default_nettype wire

// ===== hdl/emmb_trig.sv =====
// Sine lookup from a binary angle using the quarter-wave table.
`timescale 1ns / 1ps
`default_nettype none
module emmb_trig
	import emmb_pkg::*;
(
	input  wire logic               clk,
	input  wire logic [31:0]        angle,
	output logic signed [31:0]      sine
);
	logic [FracBits:0] qtab [QtrN+1];
	logic [1:0]          quad;
	logic [TrigBits-1:0] idx;
	logic [TrigBits:0]   sel;
	logic [FracBits:0]   mag_q;
	logic                neg_q;

	// Constant table of the quarter wave.
	always_comb begin
		for (int i = 0; i <= QtrN; i++)
			qtab[i] = quarter_sine(i);
	end

	// Quadrant folding.
	always_comb begin
		quad = angle[31:30];
		idx = angle[29 -: TrigBits];
		sel = quad[0] ? ((TrigBits+1)'(QtrN) - {1'b0, idx}) : {1'b0, idx};
	end

	// Registered table read; the sine appears in the cycle after its angle.
	always_ff @(posedge clk) begin
		mag_q <= qtab[sel];
		neg_q <= quad[1];
	end

	assign sine = neg_q ? -32'(signed'({1'b0, mag_q})) : 32'(signed'({1'b0, mag_q}));
endmodule
`default_nettype wire

// ===== hdl/euler_model_matrix_builder.sv =====
// Top level of the Euler model-matrix builder.
// Usage: items arrive on the in channel (cmd, value_x/y/z) and update the
// position, orientation or scale vector. Each item then produces four items
// on the out channel, columns 0..3 of M = T*Roll*Pitch*Yaw*S, with last set
// on column 3.
// Datapath: one shared 32x32 multiply-accumulate unit does all products under a
// small sequencer: 3 update steps, 6 trig lookups through a registered table
// read, 27 + 27 products for the two 3x3 products, 9 scale products, then 4
// column items. The block takes no new item until all four columns are taken,
// so a stalled receiver delays the next item.
// Reset: position and orientation clear to zero, scale to one, the channel
// goes idle. A stalled receiver holds the current column steady.
`timescale 1ns / 1ps
`default_nettype none
module euler_model_matrix_builder
	import emmb_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	emmb_in_if.sink   in_ch,
	emmb_out_if.source out_ch
);
	state_t state_q, state_d;
	logic [4:0] step_q;          // generic step counter
	logic [1:0] k_q;             // inner product index
	logic signed [31:0] pos_q [3];
	logic [31:0]        ori_q [3];
	logic signed [31:0] scl_q [3];
	logic [2:0]         cmd_q;
	logic signed [31:0] val_q [3];
	logic signed [31:0] trig_q [6];  // sp cp sy cy sr cr
	logic signed [31:0] rot_a_q [3][3];
	logic signed [31:0] rot_r_q [3][3];
	logic signed [31:0] m_q [3][3];
	logic signed [63:0] acc_q;
	logic [1:0] col_q;

	logic [31:0] trig_angle;
	logic signed [31:0] trig_sine;
	logic signed [31:0] mul_a, mul_b;
	logic signed [63:0] prod;
	logic signed [63:0] round_in;
	logic signed [63:0] rounded;
	logic signed [31:0] rounded_sat;
	logic [1:0] ri, ci;
	logic last_step;

	emmb_trig u_trig (.clk(clk), .angle(trig_angle), .sine(trig_sine));

	function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
		if (v > 65'sh7FFFFFFF) return 32'sh7FFFFFFF;
		if (v < -65'sh80000000) return 32'sh80000000;
		return v[31:0];
	endfunction

	// Element of Pitch, Yaw and Roll by position.
	function automatic logic signed [31:0] pitch_el(input logic [1:0] r, input logic [1:0] c,
			input logic signed [31:0] sp, input logic signed [31:0] cp);
		unique case ({r, c})
			4'b0000: return OneQ;
			4'b0101: return cp;
			4'b0110: return sp;
			4'b1001: return -sp;
			4'b1010: return cp;
			default: return 32'sd0;
		endcase
	endfunction

	function automatic logic signed [31:0] yaw_el(input logic [1:0] r, input logic [1:0] c,
			input logic signed [31:0] sy, input logic signed [31:0] cy);
		unique case ({r, c})
			4'b0000: return cy;
			4'b0010: return -sy;
			4'b0101: return OneQ;
			4'b1000: return sy;
			4'b1010: return cy;
			default: return 32'sd0;
		endcase
	endfunction

	function automatic logic signed [31:0] roll_el(input logic [1:0] r, input logic [1:0] c,
			input logic signed [31:0] sr, input logic signed [31:0] cr);
		unique case ({r, c})
			4'b0000: return cr;
			4'b0001: return sr;
			4'b0100: return -sr;
			4'b0101: return cr;
			4'b1010: return OneQ;
			default: return 32'sd0;
		endcase
	endfunction

	// Split of step into row and column for the 3x3 sweeps.
	always_comb begin
		ri = (step_q < 5'd3) ? 2'd0 : (step_q < 5'd6) ? 2'd1 : 2'd2;
		ci = 2'(step_q - 5'(ri) * 5'd3);
	end

	// Operand selection for the shared multiplier.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		trig_angle = ori_q[step_q[2:1] == 2'd3 ? 2'd0 : step_q[2:1]] + (step_q[0] ? 32'h40000000 : 32'h0);
		unique case (state_q)
			ST_UPDATE: begin
				mul_a = scl_q[step_q[1:0] == 2'd3 ? 2'd0 : step_q[1:0]];
				mul_b = val_q[step_q[1:0] == 2'd3 ? 2'd0 : step_q[1:0]];
			end
			ST_MUL_A: begin
				mul_a = pitch_el(ri, k_q, trig_q[0], trig_q[1]);
				mul_b = yaw_el(k_q, ci, trig_q[2], trig_q[3]);
			end
			ST_MUL_R: begin
				mul_a = roll_el(ri, k_q, trig_q[4], trig_q[5]);
				mul_b = rot_a_q[k_q][ci];
			end
			ST_SCALE: begin
				mul_a = rot_r_q[ri][ci];
				mul_b = scl_q[ci];
			end
			default: ;
		endcase
	end

	assign prod = mul_a * mul_b;
	assign round_in = acc_q + prod;
	// Half-up rounding by an arithmetic shift is a floor.
	assign rounded = (round_in + (64'sd1 <<< (FracBits - 1))) >>> FracBits;
	assign rounded_sat = sat32({rounded[63], rounded});
	assign last_step = (step_q == 5'd8);

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (in_ch.valid) state_d = ST_UPDATE;
			ST_UPDATE: if (step_q == 5'd2) state_d = ST_TRIG;
			ST_TRIG:   if (step_q == 5'd6) state_d = ST_MUL_A;
			ST_MUL_A:  if (last_step && k_q == 2'd2) state_d = ST_MUL_R;
			ST_MUL_R:  if (last_step && k_q == 2'd2) state_d = ST_SCALE;
			ST_SCALE:  if (last_step) state_d = ST_EMIT;
			ST_EMIT:   if (out_ch.ready && col_q == 2'd3) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// Output logic.
	always_comb begin
		in_ch.ready = (state_q == ST_IDLE);
		out_ch.valid = (state_q == ST_EMIT);
		out_ch.column = col_q;
		out_ch.last = (col_q == 2'd3);
		out_ch.row0 = '0;
		out_ch.row1 = '0;
		out_ch.row2 = '0;
		out_ch.row3 = '0;
		unique case (col_q)
			2'd3: begin
				out_ch.row0 = pos_q[0];
				out_ch.row1 = pos_q[1];
				out_ch.row2 = pos_q[2];
				out_ch.row3 = OneQ;
			end
			default: begin
				out_ch.row0 = m_q[0][col_q];
				out_ch.row1 = m_q[1][col_q];
				out_ch.row2 = m_q[2][col_q];
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q <= '0;
			k_q <= '0;
			col_q <= '0;
			for (int i = 0; i < 3; i++) begin
				pos_q[i] <= '0;
				ori_q[i] <= '0;
				scl_q[i] <= OneQ;
			end
		end else begin
			state_q <= state_d;
			if (state_q != state_d) begin
				step_q <= '0;
				k_q <= '0;
			end else if (state_q == ST_MUL_A || state_q == ST_MUL_R) begin
				if (k_q == 2'd2) begin
					k_q <= '0;
					step_q <= step_q + 5'd1;
				end else begin
					k_q <= k_q + 2'd1;
				end
			end else if (state_q != ST_IDLE && state_q != ST_EMIT) begin
				step_q <= step_q + 5'd1;
			end
			if (state_q == ST_EMIT && out_ch.ready)
				col_q <= col_q + 2'd1;
			// State vector update, one axis per cycle.
			if (state_q == ST_UPDATE) begin
				unique case (cmd_q)
					CMD_SET_POS: pos_q[step_q[1:0]] <= val_q[step_q[1:0]];
					CMD_SET_ORI: ori_q[step_q[1:0]] <= val_q[step_q[1:0]];
					CMD_SET_SCL: scl_q[step_q[1:0]] <= val_q[step_q[1:0]];
					CMD_MOVE: pos_q[step_q[1:0]] <= sat32(65'(pos_q[step_q[1:0]])
						+ 65'(val_q[step_q[1:0]]));
					CMD_ROTATE: ori_q[step_q[1:0]] <= ori_q[step_q[1:0]] + val_q[step_q[1:0]];
					CMD_GROW: scl_q[step_q[1:0]] <= sat32({rounded[63], rounded});
					default: ;
				endcase
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_ch.valid) begin
			cmd_q <= in_ch.cmd;
			val_q[0] <= in_ch.value_x;
			val_q[1] <= in_ch.value_y;
			val_q[2] <= in_ch.value_z;
			acc_q <= '0;
		end
		// The table read is registered, so each sine is written in the step after its angle is applied.
		if (state_q == ST_TRIG && step_q != 5'd0)
			trig_q[3'(step_q - 5'd1)] <= trig_sine;
		if (state_q == ST_MUL_A || state_q == ST_MUL_R) begin
			if (k_q == 2'd2) begin
				acc_q <= '0;
				if (state_q == ST_MUL_A) rot_a_q[ri][ci] <= rounded[31:0];
				else rot_r_q[ri][ci] <= rounded[31:0];
			end else begin
				acc_q <= round_in;
			end
		end
		if (state_q == ST_SCALE)
			m_q[ri][ci] <= rounded_sat;
	end
endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
// Testbench for the Euler model-matrix builder: directed and random items checked against a predictor.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
	import emmb_pkg::*;

	typedef struct packed {
		logic [1:0] column;
		logic signed [31:0] row0;
		logic signed [31:0] row1;
		logic signed [31:0] row2;
		logic signed [31:0] row3;
		logic last;
	} column_t;

	logic clk;
	logic arst_n;
	emmb_in_if in_ch();
	emmb_out_if out_ch();

	euler_model_matrix_builder dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch.sink),
		.out_ch(out_ch.source)
	);

	// Predicted object state.
	longint pos_q [3];
	logic [31:0] ang_q [3];
	longint scl_q [3];
	column_t expected_cols [$];
	int fail_count;
	int send_idle_pct;
	int recv_idle_pct;
	bit hold_recv;
	int quiet_cycles;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic longint clamp32(input longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	// Round half up to the fraction width; arithmetic shift floors.
	function automatic longint round_q(input longint v);
		longint w;
		w = v + (64'sd1 <<< (FracBits - 1));
		return w >>> FracBits;
	endfunction

	// Quarter-wave sine by the polynomial series of quarter_sine, with plain division.
	function automatic longint qsin(input longint unsigned i);
		longint unsigned x, x2, t, s, q;
		longint unsigned dv [5];
		dv = '{110, 72, 42, 20, 6};
		if (i >= QtrN) return longint'(OneQ);
		x = (i * 64'd1686629713) >> TrigBits;
		x2 = (x * x) >> 30;
		t = 64'd1 << 30;
		for (int k = 0; k < 5; k++)
			t = (64'd1 << 30) - ((x2 * t) >> 30) / dv[k];
		s = (x * t) >> 30;
		if (s > (64'd1 << 30)) s = 64'd1 << 30;
		q = (s + (64'd1 << (29 - FracBits))) >> (30 - FracBits);
		if (q > (64'd1 << FracBits)) q = 64'd1 << FracBits;
		return longint'(q);
	endfunction

	function automatic longint angle_sin(input logic [31:0] a);
		longint unsigned idx;
		longint v;
		idx = (a >> (30 - TrigBits)) & (QtrN - 1);
		v = a[30] ? qsin(QtrN - idx) : qsin(idx);
		return a[31] ? -v : v;
	endfunction

	// Update the state for one item and queue its four columns.
	task automatic predict_matrix(input logic [2:0] cmd, input logic signed [31:0] vx,
			input logic signed [31:0] vy, input logic signed [31:0] vz);
		longint v [3];
		longint sn [3], cs [3];
		longint yw [3][3], pt [3][3], rl [3][3], ma [3][3], mr [3][3], m [4][4];
		longint acc;
		column_t col;
		v[0] = vx; v[1] = vy; v[2] = vz;
		for (int i = 0; i < 3; i++) begin
			case (cmd)
				CMD_SET_POS: pos_q[i] = v[i];
				CMD_SET_ORI: ang_q[i] = v[i][31:0];
				CMD_SET_SCL: scl_q[i] = v[i];
				CMD_MOVE: pos_q[i] = clamp32(pos_q[i] + v[i]);
				CMD_ROTATE: ang_q[i] = ang_q[i] + v[i][31:0];
				CMD_GROW: scl_q[i] = clamp32(round_q(scl_q[i] * v[i]));
				default: ;
			endcase
		end
		for (int i = 0; i < 3; i++) begin
			sn[i] = angle_sin(ang_q[i]);
			cs[i] = angle_sin(ang_q[i] + 32'h4000_0000);
		end
		yw = '{'{cs[1], 0, -sn[1]}, '{0, longint'(OneQ), 0}, '{sn[1], 0, cs[1]}};
		pt = '{'{longint'(OneQ), 0, 0}, '{0, cs[0], sn[0]}, '{0, -sn[0], cs[0]}};
		rl = '{'{cs[2], sn[2], 0}, '{-sn[2], cs[2], 0}, '{0, 0, longint'(OneQ)}};
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++) begin
				acc = 0;
				for (int k = 0; k < 3; k++) acc += pt[i][k] * yw[k][j];
				ma[i][j] = round_q(acc);
			end
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++) begin
				acc = 0;
				for (int k = 0; k < 3; k++) acc += rl[i][k] * ma[k][j];
				mr[i][j] = round_q(acc);
			end
		for (int i = 0; i < 3; i++) begin
			for (int c = 0; c < 3; c++) m[i][c] = clamp32(round_q(mr[i][c] * scl_q[c]));
			m[i][3] = pos_q[i];
		end
		m[3] = '{0, 0, 0, longint'(OneQ)};
		for (int c = 0; c < 4; c++) begin
			col.column = c[1:0];
			col.row0 = m[0][c][31:0];
			col.row1 = m[1][c][31:0];
			col.row2 = m[2][c][31:0];
			col.row3 = m[3][c][31:0];
			col.last = (c == 3);
			expected_cols.push_back(col);
		end
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("MISMATCH %s: got %h expected %h", what, got, want);
		fail_count++;
	endtask

	// Drive one item from the next falling edge and return at the edge that accepts it.
	// Valid stays high until the next item or the drain takes over at a falling edge.
	task automatic send_item(input logic [2:0] cmd, input logic [31:0] vx,
			input logic [31:0] vy, input logic [31:0] vz);
		@(negedge clk);
		while ($urandom_range(99, 0) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.cmd <= cmd;
		in_ch.value_x <= vx;
		in_ch.value_y <= vy;
		in_ch.value_z <= vz;
		do @(posedge clk); while (!in_ch.ready);
		predict_matrix(cmd, vx, vy, vz);
	endtask

	task automatic drain_all();
		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (expected_cols.size() != 0) @(negedge clk);
	endtask

	function automatic logic [31:0] rand_value();
		case ($urandom_range(5, 0))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return $urandom_range(131072, 0) - 65536;
			3: return 32'h0001_0000;
			default: return $urandom;
		endcase
	endfunction

	// Scale factors near one keep the grow products in range most of the time.
	function automatic logic [31:0] rand_factor();
		if ($urandom_range(3, 0) == 0) return rand_value();
		return 32'h0001_0000 + $urandom_range(16384, 0) - 8192;
	endfunction

	task automatic test_directed();
		send_item(CMD_SET_POS, 32'h0, 32'h0, 32'h0);
		send_item(CMD_SET_POS, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff);
		send_item(CMD_MOVE, 32'h7fff_ffff, 32'h8000_0000, 32'h1);
		send_item(CMD_MOVE, 32'h8000_0000, 32'h7fff_ffff, 32'h0);
		send_item(CMD_SET_ORI, 32'h4000_0000, 32'h8000_0000, 32'hc000_0000);
		send_item(CMD_SET_ORI, 32'hffff_ffff, 32'h0010_0000, 32'h3fff_ffff);
		send_item(CMD_ROTATE, 32'h8000_0000, 32'hffff_ffff, 32'h7fff_ffff);
		send_item(CMD_SET_SCL, 32'h7fff_ffff, 32'h8000_0000, 32'h0);
		send_item(CMD_GROW, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
		send_item(CMD_GROW, 32'h8000_0000, 32'h0000_8000, 32'hffff_ffff);
		send_item(CMD_SET_SCL, 32'h0001_0000, 32'h0002_0000, 32'hffff_0000);
		send_item(3'd6, 32'h1234_5678, 32'h0, 32'h0);
		send_item(3'd7, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
		send_item(CMD_SET_ORI, 32'h2000_0000, 32'h6000_0000, 32'ha000_0000);
	endtask

	task automatic test_random(input int count);
		logic [2:0] cmd;
		for (int n = 0; n < count; n++) begin
			cmd = ($urandom_range(19, 0) == 0) ? 3'($urandom_range(7, 6))
				: 3'($urandom_range(5, 0));
			if (cmd == CMD_GROW)
				send_item(cmd, rand_factor(), rand_factor(), rand_factor());
			else
				send_item(cmd, rand_value(), rand_value(), rand_value());
		end
	endtask

	// Receiver stalls long while the sender keeps offering, then the sender waits for drain and sends five more items.
	task automatic test_backpressure();
		hold_recv = 1'b1;
		fork
			test_random(3);
			begin
				repeat (400) @(negedge clk);
				hold_recv = 1'b0;
			end
		join
		drain_all();
		test_random(5);
	endtask

	// Result checking at the rising edge.
	always @(posedge clk) begin
		column_t want;
		if (out_ch.valid && out_ch.ready) begin
			if (expected_cols.size() == 0) begin
				report_mismatch("unexpected item", out_ch.row0, 32'h0);
			end else begin
				want = expected_cols.pop_front();
				if (out_ch.column !== want.column)
					report_mismatch("column", out_ch.column, want.column);
				if (out_ch.row0 !== want.row0) report_mismatch("row0", out_ch.row0, want.row0);
				if (out_ch.row1 !== want.row1) report_mismatch("row1", out_ch.row1, want.row1);
				if (out_ch.row2 !== want.row2) report_mismatch("row2", out_ch.row2, want.row2);
				if (out_ch.row3 !== want.row3) report_mismatch("row3", out_ch.row3, want.row3);
				if (out_ch.last !== want.last) report_mismatch("last", out_ch.last, want.last);
			end
		end
	end

	// Receiver readiness changes at the falling edge.
	always @(negedge clk) begin
		out_ch.ready <= !hold_recv && ($urandom_range(99, 0) >= recv_idle_pct);
	end

	// Watchdog on cycles with no handshake on either channel.
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > 5000) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < 3; i++) begin
			pos_q[i] = 0;
			ang_q[i] = 0;
			scl_q[i] = longint'(OneQ);
		end
		fail_count = 0;
		quiet_cycles = 0;
		hold_recv = 1'b0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		in_ch.valid = 1'b0;
		in_ch.cmd = '0;
		in_ch.value_x = '0;
		in_ch.value_y = '0;
		in_ch.value_z = '0;
		out_ch.ready = 1'b0;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_idle_pct = 18;
		recv_idle_pct = 76;
		test_directed();
		test_random(140);
		test_backpressure();
		send_idle_pct = 76;
		recv_idle_pct = 18;
		test_random(150);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random(140);

		drain_all();
		repeat (100) @(negedge clk);
		if (fail_count == 0 && expected_cols.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end
endmodule
`default_nettype wire
